### hdl/sfbp_pkg.sv
// shared constants, codes and types of the striped free buffer pool
package sfbp_pkg;

  // pool geometry
  localparam int NUM_BUFFERS  = 1024;
  localparam int NUM_CHANNELS = 10;
  localparam int STACK_DEPTH  = 128;

  // fixed field widths
  localparam int CMD_W  = 2;
  localparam int CHAN_W = 16;
  localparam int IDX_W  = 10;
  localparam int CNT_W  = 11;
  localparam int SIZE_W = 16;
  localparam int OFF_W  = 26;
  localparam int FREE_W = 11;
  localparam int DATA_W = 16;

  // derived widths
  localparam int POOL_TOTAL = NUM_CHANNELS * STACK_DEPTH;
  localparam int CH_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int DEPTH_W    = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W     = (POOL_TOTAL > 1) ? $clog2(POOL_TOTAL) : 1;

  // rounded-up reciprocal of the channel count, exact for every channel-wide word
  localparam int MOD_SHIFT = CHAN_W + $clog2(NUM_CHANNELS);
  localparam int RECIP_W   = CHAN_W + 1;
  localparam int PROD_W    = CHAN_W + RECIP_W;
  localparam logic [RECIP_W-1:0] MOD_RECIP =
    RECIP_W'(((1 << MOD_SHIFT) + NUM_CHANNELS - 1) / NUM_CHANNELS);

  // register reset values
  localparam logic [CNT_W-1:0]  COUNT_RESET = 11'd1024;
  localparam logic [SIZE_W-1:0] SIZE_RESET  = 16'd1024;

  // register indexes
  localparam logic REG_BUFFER_COUNT = 1'b0;
  localparam logic REG_BUFFER_SIZE  = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT    = 2'd0,
    CMD_GET     = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_REM,
    ST_SCAN,
    ST_READ
  } state_t;

  // request and response of the remainder unit
  typedef struct packed {
    logic              load;
    logic [CHAN_W-1:0] operand;
  } mod_req_t;

  typedef struct packed {
    logic            done;
    logic [CH_W-1:0] rem;
  } mod_rsp_t;

endpackage

### hdl/sfbp_mod_unit.sv
// remainder of an unsigned word by the channel count, by reciprocal multiplication
module sfbp_mod_unit import sfbp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mod_req_t req,
  output mod_rsp_t rsp
);

  logic [CHAN_W-1:0] opnd_r, opnd_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [CH_W-1:0]   rem_r, rem_nxt;
  logic              load_r, mul_r, done_r;
  logic [CHAN_W-1:0] quot;
  logic [CHAN_W-1:0] diff;

  // second step takes the quotient multiple back off the operand
  always_comb begin
    quot = CHAN_W'(prod_r >> MOD_SHIFT);
    diff = opnd_r - CHAN_W'(quot * CHAN_W'(NUM_CHANNELS));
  end

  always_comb begin
    opnd_nxt = opnd_r;
    prod_nxt = prod_r;
    rem_nxt  = rem_r;
    if (req.load) begin
      opnd_nxt = req.operand;
    end
    // first step after the load scales by the reciprocal
    if (load_r) begin
      prod_nxt = PROD_W'(opnd_r) * PROD_W'(MOD_RECIP);
    end
    if (mul_r) begin
      rem_nxt = diff[CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_r <= 1'b0;
      mul_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      load_r <= req.load;
      mul_r  <= load_r;
      done_r <= mul_r;
    end
  end

  always_ff @(posedge clk) begin
    opnd_r <= opnd_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

### hdl/striped_free_buffer_pool.sv
// striped free buffer pool: free lists on per-channel lifo stacks
//
// A command is taken when start is high and busy is low; busy then stays high until
// the cycle in which the result is shown on the out_ ports with out_strobe high for
// exactly one cycle, which the receiver must take. Init walks the buffers up to
// buffer_count (clamped to NUM_BUFFERS), one buffer pushed a cycle. Get and release
// first pass the channel magnitude or the buffer index through a remainder unit that
// multiplies by a reciprocal of the channel count; release then pushes, and get pops
// when the chosen stack holds a buffer. A get whose stack is empty, or whose channel
// has a negative remainder, scans from stack 0 at one stack a cycle to the first
// stack that holds a buffer, and fails when every stack is empty. A popped entry is
// read into a register before the offset multiply. An unused command code raises
// out_strobe at the accepting edge itself, so its word is shown in the next cycle.
// No clearing pass is needed after reset. out_free_count always shows the total of
// free buffers after the step whose result is strobed.
module striped_free_buffer_pool import sfbp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic signed [CHAN_W-1:0] in_channel,
  input  logic [IDX_W-1:0]         in_buffer_index,
  output logic                     out_strobe,
  output logic                     out_ok,
  output logic [IDX_W-1:0]         out_granted_index,
  output logic [OFF_W-1:0]         out_byte_offset,
  output logic [FREE_W-1:0]        out_free_count,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data
);

  state_t state_r, state_nxt;

  cmd_t              cmd_r;
  logic              neg_r;
  logic [IDX_W-1:0]  idx_r;
  logic [CNT_W-1:0]  fill_i_r, fill_n_r;
  logic [CH_W-1:0]   fill_ch_r, scan_r;
  logic [DEPTH_W-1:0] depth_r [NUM_CHANNELS];
  logic [FREE_W-1:0] free_r;
  logic [CNT_W-1:0]  cfg_count_r;
  logic [SIZE_W-1:0] cfg_size_r;
  logic              out_strobe_r, out_ok_r;
  logic [IDX_W-1:0]  out_granted_r;
  logic [OFF_W-1:0]  out_offset_r;
  logic [IDX_W-1:0]  rd_data_r;
  logic [IDX_W-1:0]  mem [POOL_TOTAL];

  logic              accept;
  cmd_t              in_cmd_e;
  logic [CHAN_W-1:0] chan_u, chan_mag;
  logic [CNT_W-1:0]  limit;
  logic [CH_W-1:0]   didx;
  logic [DEPTH_W-1:0] dsel;
  logic              full, empty, direct;
  logic              push, pop, finish, fin_ok;
  logic [ADDR_W-1:0] addr;
  logic [IDX_W-1:0]  wdata;
  mod_req_t          mod_req;
  mod_rsp_t          mod_rsp;

  sfbp_mod_unit u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  assign accept   = start && (state_r == ST_IDLE);
  assign busy     = (state_r != ST_IDLE);
  assign in_cmd_e = cmd_t'(in_cmd);

  // magnitude of the channel; the most negative value maps to its unsigned magnitude
  assign chan_u   = in_channel;
  assign chan_mag = chan_u[CHAN_W-1] ? (~chan_u + CHAN_W'(1)) : chan_u;

  assign mod_req.load    = accept && ((in_cmd_e == CMD_GET) || (in_cmd_e == CMD_RELEASE));
  assign mod_req.operand = (in_cmd_e == CMD_GET) ? chan_mag : CHAN_W'(in_buffer_index);

  assign limit  = (32'(cfg_count_r) < NUM_BUFFERS) ? cfg_count_r : CNT_W'(NUM_BUFFERS);
  // a negative channel with a non-zero remainder goes straight to the scan
  assign direct = !neg_r || (mod_rsp.rem == '0);

  assign dsel  = depth_r[didx];
  assign full  = (dsel >= DEPTH_W'(STACK_DEPTH));
  assign empty = (dsel == '0);
  assign addr  = ADDR_W'(ADDR_W'(didx) * ADDR_W'(STACK_DEPTH))
               + ADDR_W'(pop ? (dsel - DEPTH_W'(1)) : dsel);

  // datapath controls
  always_comb begin
    didx   = '0;
    push   = 1'b0;
    pop    = 1'b0;
    finish = 1'b0;
    fin_ok = 1'b0;
    wdata  = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_cmd_e != CMD_INIT) && (in_cmd_e != CMD_GET)
            && (in_cmd_e != CMD_RELEASE)) begin
          finish = 1'b1;
        end
      end
      ST_FILL: begin
        didx = fill_ch_r;
        if (fill_i_r == fill_n_r) begin
          finish = 1'b1;
          fin_ok = 1'b1;
        end else if (!full) begin
          push  = 1'b1;
          wdata = fill_i_r[IDX_W-1:0];
        end
      end
      ST_REM: begin
        didx = mod_rsp.rem;
        if (mod_rsp.done) begin
          if (cmd_r == CMD_GET) begin
            pop = direct && !empty;
          end else begin
            push   = ({1'b0, idx_r} < limit) && !full;
            finish = 1'b1;
            fin_ok = push;
          end
        end
      end
      ST_SCAN: begin
        didx = scan_r;
        if (!empty) begin
          pop = 1'b1;
        end else if (scan_r == CH_W'(NUM_CHANNELS - 1)) begin
          finish = 1'b1;
        end
      end
      ST_READ: begin
        finish = 1'b1;
        fin_ok = 1'b1;
      end
      default: begin
        finish = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_cmd_e)
            CMD_INIT:    state_nxt = ST_FILL;
            CMD_GET:     state_nxt = ST_REM;
            CMD_RELEASE: state_nxt = ST_REM;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_FILL: begin
        if (finish) state_nxt = ST_IDLE;
      end
      ST_REM: begin
        if (mod_rsp.done) begin
          if (cmd_r == CMD_GET) begin
            state_nxt = pop ? ST_READ : ST_SCAN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_SCAN: begin
        if (pop) begin
          state_nxt = ST_READ;
        end else if (finish) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      free_r       <= '0;
      cfg_count_r  <= COUNT_RESET;
      cfg_size_r   <= SIZE_RESET;
      out_strobe_r <= 1'b0;
      for (int c = 0; c < NUM_CHANNELS; c++) depth_r[c] <= '0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= finish;
      if (cfg_we) begin
        case (cfg_index)
          REG_BUFFER_COUNT: cfg_count_r <= cfg_data[CNT_W-1:0];
          REG_BUFFER_SIZE:  cfg_size_r  <= cfg_data[SIZE_W-1:0];
          default:          cfg_size_r  <= cfg_size_r;
        endcase
      end
      if (accept && (in_cmd_e == CMD_INIT)) begin
        free_r <= '0;
        for (int c = 0; c < NUM_CHANNELS; c++) depth_r[c] <= '0;
      end else if (push) begin
        depth_r[didx] <= dsel + DEPTH_W'(1);
        free_r        <= free_r + FREE_W'(1);
      end else if (pop) begin
        depth_r[didx] <= dsel - DEPTH_W'(1);
        free_r        <= free_r - FREE_W'(1);
      end
    end
  end

  // command word, fill walk and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r         <= in_cmd_e;
      neg_r         <= in_channel[CHAN_W-1];
      idx_r         <= in_buffer_index;
      fill_i_r      <= '0;
      fill_ch_r     <= '0;
      fill_n_r      <= limit;
      scan_r        <= '0;
      out_granted_r <= '0;
      out_offset_r  <= '0;
    end
    if ((state_r == ST_FILL) && !finish) begin
      fill_i_r  <= fill_i_r + CNT_W'(1);
      fill_ch_r <= (fill_ch_r == CH_W'(NUM_CHANNELS - 1)) ? '0 : fill_ch_r + CH_W'(1);
    end
    if ((state_r == ST_SCAN) && !pop && !finish) begin
      scan_r <= scan_r + CH_W'(1);
    end
    if (state_r == ST_READ) begin
      out_granted_r <= rd_data_r;
      out_offset_r  <= OFF_W'(rd_data_r) * OFF_W'(cfg_size_r);
    end
    if (finish) begin
      out_ok_r <= fin_ok;
    end
  end

  // stack memory, one access a cycle
  always_ff @(posedge clk) begin
    if (push) begin
      mem[addr] <= wdata;
    end
    if (pop) begin
      rd_data_r <= mem[addr];
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_ok            = out_ok_r;
  assign out_granted_index = out_granted_r;
  assign out_byte_offset   = out_offset_r;
  assign out_free_count    = free_r;

endmodule

### hdl/sfbp_checker.sv
// port-level checks of the striped free buffer pool, bound to the top level
module sfbp_checker import sfbp_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              busy,
  input logic              out_strobe,
  input logic              out_ok,
  input logic [IDX_W-1:0]  out_granted_index,
  input logic [OFF_W-1:0]  out_byte_offset,
  input logic [FREE_W-1:0] out_free_count
);

  // a result word closes the command, so the block is ready in that cycle
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result word shown while busy");

  // busy only drops when a result word comes out
  a_busy_ends_in_word: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("busy dropped without a result word");

  // a failed word carries no grant
  a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_ok) |-> (out_granted_index == '0) && (out_byte_offset == '0))
    else $error("grant fields set on a failed word");

  // at each result word, the free total does not exceed what the stacks can hold
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (32'(out_free_count) <= POOL_TOTAL))
    else $error("free count above pool capacity");

endmodule

bind striped_free_buffer_pool sfbp_checker u_sfbp_checker (.*);

### test/tb_top.sv
// self-checking testbench for the striped free buffer pool, with its own pool predictor
module tb_top;
  import sfbp_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 1850;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [CMD_W-1:0]         in_cmd;
  logic signed [CHAN_W-1:0] in_channel;
  logic [IDX_W-1:0]         in_buffer_index;
  logic                     out_strobe;
  logic                     out_ok;
  logic [IDX_W-1:0]         out_granted_index;
  logic [OFF_W-1:0]         out_byte_offset;
  logic [FREE_W-1:0]        out_free_count;
  logic                     cfg_we;
  logic                     cfg_index;
  logic [DATA_W-1:0]        cfg_data;

  typedef struct packed {
    logic              ok;
    logic [IDX_W-1:0]  granted;
    logic [OFF_W-1:0]  offset;
    logic [FREE_W-1:0] free;
  } pool_word_t;

  // predicted pool contents and the result words still owed by the block
  class pool_scoreboard;
    logic [IDX_W-1:0] stacks [NUM_CHANNELS][STACK_DEPTH];
    int depth [NUM_CHANNELS];
    int free_total;
    int count_reg;
    int size_reg;
    pool_word_t expected_q[$];
    int errors, results, grants, empty_gets, range_rejects, full_rejects;

    function new();
      count_reg = int'(COUNT_RESET);
      size_reg = int'(SIZE_RESET);
      free_total = 0;
      foreach (depth[c]) depth[c] = 0;
      errors = 0;
      results = 0;
      grants = 0;
      empty_gets = 0;
      range_rejects = 0;
      full_rejects = 0;
    endfunction

    function void set_reg(logic idx, logic [DATA_W-1:0] data);
      case (idx)
        REG_BUFFER_COUNT: count_reg = int'(data[CNT_W-1:0]);
        REG_BUFFER_SIZE:  size_reg = int'(data[SIZE_W-1:0]);
        default: ;
      endcase
    endfunction

    function int loaded_limit();
      return (count_reg < NUM_BUFFERS) ? count_reg : NUM_BUFFERS;
    endfunction

    function bit push(int b);
      int c;
      c = b % NUM_CHANNELS;
      if (depth[c] >= STACK_DEPTH) return 1'b0;
      stacks[c][depth[c]] = IDX_W'(b);
      depth[c]++;
      free_total++;
      return 1'b1;
    endfunction

    function bit pop(int c, output int b);
      b = 0;
      if (depth[c] == 0) return 1'b0;
      depth[c]--;
      b = int'(stacks[c][depth[c]]);
      free_total--;
      return 1'b1;
    endfunction

    function pool_word_t note_word(logic [CMD_W-1:0] cmd, logic signed [CHAN_W-1:0] chan,
                                   logic [IDX_W-1:0] bidx);
      pool_word_t w;
      int rem, b, i;
      bit got;
      w = '0;
      b = 0;
      got = 1'b0;
      case (cmd)
        CMD_INIT: begin
          foreach (depth[c]) depth[c] = 0;
          free_total = 0;
          for (i = 0; i < loaded_limit(); i++) void'(push(i));
          w.ok = 1'b1;
        end
        CMD_GET: begin
          // remainder truncates toward zero, so -10 lands on stack 0
          rem = int'(chan) % NUM_CHANNELS;
          if (rem >= 0) got = pop(rem, b);
          for (i = 0; i < NUM_CHANNELS && !got; i++) got = pop(i, b);
          if (got) begin
            w.ok = 1'b1;
            w.granted = IDX_W'(b);
            w.offset = OFF_W'(longint'(b) * longint'(size_reg));
            grants++;
          end else begin
            empty_gets++;
          end
        end
        CMD_RELEASE: begin
          if (bidx >= loaded_limit()) range_rejects++;
          else if (push(int'(bidx))) w.ok = 1'b1;
          else full_rejects++;
        end
        default: ;
      endcase
      w.free = FREE_W'(free_total);
      expected_q.push_back(w);
      return w;
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_word(pool_word_t act);
      pool_word_t w;
      results++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing expected, ok %0d index %0d free %0d",
                 $time, act.ok, act.granted, act.free);
        return;
      end
      w = expected_q.pop_front();
      compare_field("ok", 32'(w.ok), 32'(act.ok));
      compare_field("granted index", 32'(w.granted), 32'(act.granted));
      compare_field("byte offset", 32'(w.offset), 32'(act.offset));
      compare_field("free count", 32'(w.free), 32'(act.free));
    endfunction
  endclass

  pool_scoreboard pool_sb;
  int idle_pct;
  int n_words;
  int held_q[$];

  striped_free_buffer_pool dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_channel        (in_channel),
    .in_buffer_index   (in_buffer_index),
    .out_strobe        (out_strobe),
    .out_ok            (out_ok),
    .out_granted_index (out_granted_index),
    .out_byte_offset   (out_byte_offset),
    .out_free_count    (out_free_count),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      pool_sb.check_word({out_ok, out_granted_index, out_byte_offset, out_free_count});
    end
  end

  function automatic logic signed [CHAN_W-1:0] rand_channel();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return CHAN_W'($urandom_range(0, NUM_CHANNELS - 1));
      5, 6: return CHAN_W'($urandom());
      7, 8: return CHAN_W'(-int'($urandom_range(1, 40)));
      default: begin
        case ($urandom_range(3))
          0: return 16'sh7FFF;
          1: return 16'sh8000;
          2: return -16'sd10;
          default: return 16'sd9;
        endcase
      end
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] rand_index();
    return IDX_W'($urandom());
  endfunction

  // leaves start high so a following word can go out without a gap
  task automatic send_word(logic [CMD_W-1:0] cmd, logic signed [CHAN_W-1:0] chan,
                           logic [IDX_W-1:0] bidx);
    pool_word_t w;
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= cmd;
    in_channel <= chan;
    in_buffer_index <= bidx;
    do @(posedge clk); while (busy !== 1'b0);
    w = pool_sb.note_word(cmd, chan, bidx);
    if (cmd == CMD_GET && w.ok) held_q.push_back(int'(w.granted));
    if (cmd == CMD_INIT) held_q.delete();
    if (cmd != CMD_UNUSED) n_words++;
  endtask

  task automatic wait_pool_idle();
    start <= 1'b0;
    while (pool_sb.expected_q.size() != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  task automatic write_settings(logic [DATA_W-1:0] cnt, logic [DATA_W-1:0] sz);
    wait_pool_idle();
    cfg_we <= 1'b1;
    cfg_index <= REG_BUFFER_COUNT;
    cfg_data <= cnt;
    @(posedge clk);
    pool_sb.set_reg(REG_BUFFER_COUNT, cnt);
    cfg_index <= REG_BUFFER_SIZE;
    cfg_data <= sz;
    @(posedge clk);
    pool_sb.set_reg(REG_BUFFER_SIZE, sz);
    cfg_we <= 1'b0;
  endtask

  task automatic release_held();
    int pos;
    if (held_q.size() == 0) begin
      send_word(CMD_GET, rand_channel(), rand_index());
    end else begin
      pos = $urandom_range(0, held_q.size() - 1);
      send_word(CMD_RELEASE, rand_channel(), IDX_W'(held_q[pos]));
      held_q.delete(pos);
    end
  endtask

  // allocate and give back buffers that were actually granted
  task automatic run_churn(int n);
    repeat (n) begin
      if ($urandom_range(99) < 55 || held_q.size() == 0) begin
        send_word(CMD_GET, rand_channel(), rand_index());
      end else begin
        release_held();
      end
    end
  endtask

  task automatic run_drain();
    int n;
    n = pool_sb.free_total + 2;
    if (n > 60) n = 60;
    repeat (n) send_word(CMD_GET, rand_channel(), rand_index());
  endtask

  // push one stack past its depth through repeated releases
  task automatic run_flood();
    int k, lim, n;
    k = $urandom_range(0, NUM_CHANNELS - 1);
    lim = pool_sb.loaded_limit();
    if (k >= lim) return;
    n = STACK_DEPTH - pool_sb.depth[k] + 2;
    repeat (n) begin
      send_word(CMD_RELEASE, rand_channel(),
                IDX_W'(k + NUM_CHANNELS * $urandom_range(0, (lim - 1 - k) / NUM_CHANNELS)));
    end
  endtask

  task automatic run_noise(int n);
    logic [CMD_W-1:0] cmd;
    repeat (n) begin
      case ($urandom_range(9))
        0: cmd = CMD_INIT;
        1, 2, 3, 4: cmd = CMD_GET;
        5, 6, 7: cmd = CMD_RELEASE;
        default: cmd = CMD_UNUSED;
      endcase
      send_word(cmd, CHAN_W'($urandom()), rand_index());
    end
  endtask

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [DATA_W-1:0] cnt, sz;
    int phase, setting_end, wait_cycles;
    pool_sb = new();
    idle_pct = 0;
    n_words = 0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_cmd <= CMD_INIT;
    in_channel <= '0;
    in_buffer_index <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_BUFFER_COUNT;
    cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed words, starting from the reset register values
    send_word(CMD_GET, 16'sd0, 10'd0);
    send_word(CMD_UNUSED, 16'sd3, 10'd3);
    send_word(CMD_RELEASE, 16'sd0, 10'd1023);
    send_word(CMD_GET, -16'sd1, 10'd0);
    send_word(CMD_GET, 16'sh7FFF, 10'd0);
    // upper bits of the count word are dropped, leaving 12 buffers
    write_settings(16'hF80C, 16'hFFFF);
    send_word(CMD_INIT, 16'sd0, 10'd0);
    send_word(CMD_GET, 16'sh7FFF, 10'd0);
    send_word(CMD_GET, 16'sh8000, 10'd0);
    send_word(CMD_GET, 16'sd7, 10'd0);
    send_word(CMD_GET, -16'sd10, 10'd0);
    send_word(CMD_RELEASE, 16'sd0, 10'd12);
    send_word(CMD_RELEASE, 16'sd0, 10'd11);
    send_word(CMD_RELEASE, 16'sd0, 10'd11);
    send_word(CMD_RELEASE, 16'sd0, 10'd1023);
    write_settings(16'd0, 16'd1);
    send_word(CMD_INIT, 16'sd0, 10'd0);
    send_word(CMD_GET, 16'sd5, 10'd0);
    send_word(CMD_RELEASE, 16'sd0, 10'd0);
    // count above the pool size is clamped
    write_settings(16'hFFFF, 16'hFFFF);
    send_word(CMD_INIT, 16'sd0, 10'd0);
    send_word(CMD_GET, 16'sd9, 10'd0);
    send_word(CMD_GET, 16'sd3, 10'd0);
    send_word(CMD_GET, 16'sh8000, 10'd0);
    send_word(CMD_RELEASE, 16'sd0, 10'd1023);
    send_word(CMD_RELEASE, 16'sd0, 10'd0);

    n_words = 0;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: idle_pct = 0;
        1: idle_pct = 72;
        2: idle_pct = 0;
        default: idle_pct = 9;
      endcase
      case (phase)
        0: {cnt, sz} = {16'd1024, 16'hFFFF};
        1: {cnt, sz} = {16'd1, 16'd1};
        2: {cnt, sz} = {16'hFFFF, 16'd1};
        default: {cnt, sz} = {16'd0, 16'd32768};
      endcase
      while (n_words < (phase + 1) * RANDOM_WORDS / 4) begin
        write_settings(cnt, sz);
        send_word(CMD_INIT, rand_channel(), rand_index());
        setting_end = n_words + $urandom_range(80, 200);
        while (n_words < setting_end && n_words < (phase + 1) * RANDOM_WORDS / 4) begin
          case ($urandom_range(19))
            0, 1, 2, 3, 4, 5, 6, 7, 8: run_churn($urandom_range(5, 40));
            9, 10, 11: run_drain();
            12, 13, 14: run_flood();
            15, 16, 17: run_noise($urandom_range(4, 12));
            default: begin
              send_word(CMD_INIT, rand_channel(), rand_index());
              run_churn($urandom_range(5, 20));
            end
          endcase
        end
        case ($urandom_range(5))
          0, 4: cnt = 16'd1024;
          1: cnt = DATA_W'($urandom_range(0, 30));
          2: cnt = DATA_W'($urandom_range(31, 1023));
          3: cnt = DATA_W'($urandom());
          default: cnt = DATA_W'($urandom_range(1, 200));
        endcase
        case ($urandom_range(3))
          0: sz = 16'd1;
          1: sz = 16'hFFFF;
          2: sz = DATA_W'($urandom_range(1, 65535));
          default: sz = DATA_W'($urandom_range(1, 64));
        endcase
      end
    end

    start <= 1'b0;
    wait_cycles = 0;
    while (pool_sb.expected_q.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (40) @(posedge clk);
    if (pool_sb.expected_q.size() != 0) begin
      pool_sb.errors++;
      $display("%0t: %0d result words never arrived", $time, pool_sb.expected_q.size());
    end

    $display("checked %0d result words after %0d random words: %0d grants, %0d empty gets",
             pool_sb.results, n_words, pool_sb.grants, pool_sb.empty_gets);
    $display("releases turned away: %0d out of range, %0d onto a full stack",
             pool_sb.range_rejects, pool_sb.full_rejects);
    if (pool_sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
hdl/sfbp_pkg.sv
hdl/sfbp_mod_unit.sv
hdl/striped_free_buffer_pool.sv
hdl/sfbp_checker.sv
test/tb_top.sv
